// File: hdl/mjdcal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MJD to calendar conversion package
// Types and fixed constants for the MJD to calendar date pipeline. Each
// division by a constant is a multiplication by a rounded-up reciprocal
// followed by a shift, exact over the operand width in use.
// ----------------------------------------------------------------------------
package mjdcal_pkg;

  // time of day split into its fields
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] msec;
  } tod_t;

  localparam logic [26:0] MsDayMax   = 27'd86399999;
  localparam logic signed [20:0] MjdGregStart = -21'sd100840;

  // offsets folding the MJD into the Meeus intermediates
  localparam logic signed [23:0] AlphaBias  = 24'sd2131139;
  localparam logic signed [22:0] BJulian    = 23'sd2401525;
  localparam logic [28:0]        CBias      = 29'd12210;
  localparam logic signed [14:0] YearEarly  = 15'sd4715;
  localparam logic signed [14:0] YearLate   = 15'sd4716;
  localparam logic [3:0]         EYearWrap  = 4'd14;
  localparam logic [3:0]         EOffLow    = 4'd1;
  localparam logic [3:0]         EOffHigh   = 4'd13;
  localparam logic [3:0]         MonthFeb   = 4'd2;

  // alpha = n / 146097, n < 2^23
  localparam int K1 = 41;
  localparam logic [23:0] M1 = 24'(((64'd1 << K1) + 64'd146097 - 64'd1) / 64'd146097);
  // seconds = ms / 1000, ms < 2^27
  localparam int KS = 37;
  localparam logic [27:0] MS = 28'(((64'd1 << KS) + 64'd1000 - 64'd1) / 64'd1000);
  // minutes = s / 60, s < 2^17
  localparam int KM = 23;
  localparam logic [17:0] MM = 18'(((64'd1 << KM) + 64'd60 - 64'd1) / 64'd60);
  // hours = m / 60, m < 2^11
  localparam int KH = 17;
  localparam logic [11:0] MH = 12'(((64'd1 << KH) + 64'd60 - 64'd1) / 64'd60);
  // c = n / 36525, n < 2^29
  localparam int K2 = 45;
  localparam logic [29:0] M2 = 30'(((64'd1 << K2) + 64'd36525 - 64'd1) / 64'd36525);
  // e = n / 306001, n < 2^23
  localparam int K3 = 42;
  localparam logic [23:0] M3 = 24'(((64'd1 << K3) + 64'd306001 - 64'd1) / 64'd306001);

  // floor(30.6001 * e) for each value of e
  localparam logic [8:0] MonthOffset [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

endpackage
`default_nettype wire

// File: hdl/modified_julian_date_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modified Julian Date to calendar date and time
// Pipelined conversion of an MJD day count and milliseconds of day into
// year, month, day, hour, minute, second and millisecond.
// ----------------------------------------------------------------------------
// Usage:
//   Present mjd_day_i and ms_of_day_i with start_i high; the transaction is
//   taken at a rising edge where start_i is high and busy_o is low. busy_o
//   stays low, so one transaction can be taken on every clock cycle.
//   A transaction taken at a rising edge passes through the pipeline stages and
//   puts its result on the output ports, marked by done_o for that one cycle
//   only, and the result is taken at the rising edge that ends that cycle.
//   Throughput is one transaction per cycle, set by a nine-stage pipeline
//   with at most one reciprocal multiply on any path through a stage.
//   Days from MJD -100840 on use the Gregorian calendar, earlier days the
//   Julian one. A millisecond count above 86399999 saturates to 23:59:59.999.
//   Reset clears the stage valid bits; transactions in flight are dropped.
//   The receiver cannot hold results off and must take each on done_o.
// ----------------------------------------------------------------------------
module modified_julian_date_to_calendar (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               start_i,
  output logic                     busy_o,
  input  wire  logic signed [20:0] mjd_day_i,
  input  wire  logic        [26:0] ms_of_day_i,
  output logic                     done_o,
  output logic signed [13:0]       year_o,
  output logic        [3:0]        month_o,
  output logic        [4:0]        day_o,
  output logic        [4:0]        hour_o,
  output logic        [5:0]        minute_o,
  output logic        [5:0]        second_o,
  output logic        [9:0]        millisecond_o
);
  import mjdcal_pkg::*;

  localparam int Latency = 9;

  logic [Latency-1:0] valid_q, valid_d;

  // stage 1
  logic                greg1_q, greg1_d;
  logic signed [20:0]  mjd1_q;
  logic [22:0]         n1_q, n1_d;
  logic [26:0]         ms1_q, ms1_d;
  logic signed [23:0]  n1_sum;
  // stage 2
  logic                greg2_q;
  logic signed [20:0]  mjd2_q;
  logic [46:0]         p1_q, p1_d;
  logic [54:0]         ps_q, ps_d;
  logic [26:0]         ms2_q;
  // stage 3
  logic [21:0]         b3_q, b3_d;
  logic [16:0]         s3_q, s3_d;
  logic [9:0]          msec3_q, msec3_d;
  logic [34:0]         pm_q, pm_d;
  logic [5:0]          alpha, adj;
  logic signed [22:0]  b_sum;
  // stage 4
  logic [21:0]         b4_q;
  logic [28:0]         n2_q, n2_d;
  logic [5:0]          sec4_q, sec4_d;
  logic [10:0]         m4_q, m4_d;
  logic [22:0]         ph_q, ph_d;
  logic [9:0]          msec4_q;
  // stage 5
  logic [58:0]         p2_q, p2_d;
  logic [21:0]         b5_q;
  tod_t                tod5_q, tod5_d;
  logic [4:0]          h5;
  // stage 6
  logic [13:0]         c6_q, c6_d;
  logic [8:0]          bd6_q, bd6_d;
  tod_t                tod6_q;
  logic [24:0]         d_prod;
  // stage 7
  logic [13:0]         c7_q;
  logic [8:0]          bd7_q;
  logic [22:0]         n3_q, n3_d;
  tod_t                tod7_q;
  // stage 8
  logic [13:0]         c8_q;
  logic [8:0]          bd8_q;
  logic [46:0]         p3_q, p3_d;
  tod_t                tod8_q;
  // stage 9
  logic signed [13:0]  year_q, year_d;
  logic [3:0]          month_q, month_d;
  logic [4:0]          day_q, day_d;
  tod_t                tod9_q;
  logic [3:0]          e9;
  logic signed [14:0]  yr_full;

  assign busy_o  = 1'b0;
  assign valid_d = {valid_q[Latency-2:0], start_i & ~busy_o};

  always_comb begin
    greg1_d = (mjd_day_i >= MjdGregStart);
    n1_sum  = 24'($signed({mjd_day_i, 2'b00})) + AlphaBias;
    n1_d    = greg1_d ? n1_sum[22:0] : '0;
    ms1_d   = (ms_of_day_i > MsDayMax) ? MsDayMax : ms_of_day_i;

    p1_d = 47'(n1_q) * 47'(M1);
    ps_d = 55'(ms1_q) * 55'(MS);

    alpha   = p1_q[K1 +: 6];
    adj     = greg2_q ? 6'(6'd1 + alpha - {2'b00, alpha[5:2]}) : '0;
    b_sum   = 23'(mjd2_q) + BJulian + $signed({17'd0, adj});
    b3_d    = b_sum[21:0];
    s3_d    = ps_q[KS +: 17];
    msec3_d = 10'(ms2_q - 27'(27'(s3_d) * 27'd1000));
    pm_d    = 35'(s3_d) * 35'(MM);

    n2_d   = 29'(29'(b3_q) * 29'd100) - CBias;
    m4_d   = pm_q[KM +: 11];
    sec4_d = 6'(s3_q - 17'(17'(m4_d) * 17'd60));
    ph_d   = 23'(m4_d) * 23'(MH);

    p2_d          = 59'(n2_q) * 59'(M2);
    h5            = ph_q[KH +: 5];
    tod5_d.hour   = h5;
    tod5_d.minute = 6'(m4_q - 11'(11'(h5) * 11'd60));
    tod5_d.second = sec4_q;
    tod5_d.msec   = msec4_q;

    c6_d   = p2_q[K2 +: 14];
    d_prod = 25'(c6_d) * 25'd1461;
    bd6_d  = 9'(b5_q - d_prod[23:2]);

    n3_d = 23'(bd6_q) * 23'd10000;

    p3_d = 47'(n3_q) * 47'(M3);

    e9      = p3_q[K3 +: 4];
    day_d   = 5'(bd8_q - MonthOffset[e9]);
    month_d = (e9 < EYearWrap) ? (e9 - EOffLow) : (e9 - EOffHigh);
    yr_full = $signed({1'b0, c8_q}) - ((month_d > MonthFeb) ? YearLate : YearEarly);
    year_d  = yr_full[13:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    greg1_q <= greg1_d;
    mjd1_q  <= mjd_day_i;
    n1_q    <= n1_d;
    ms1_q   <= ms1_d;

    greg2_q <= greg1_q;
    mjd2_q  <= mjd1_q;
    p1_q    <= p1_d;
    ps_q    <= ps_d;
    ms2_q   <= ms1_q;

    b3_q    <= b3_d;
    s3_q    <= s3_d;
    msec3_q <= msec3_d;
    pm_q    <= pm_d;

    b4_q    <= b3_q;
    n2_q    <= n2_d;
    sec4_q  <= sec4_d;
    m4_q    <= m4_d;
    ph_q    <= ph_d;
    msec4_q <= msec3_q;

    p2_q   <= p2_d;
    b5_q   <= b4_q;
    tod5_q <= tod5_d;

    c6_q   <= c6_d;
    bd6_q  <= bd6_d;
    tod6_q <= tod5_q;

    c7_q   <= c6_q;
    bd7_q  <= bd6_q;
    n3_q   <= n3_d;
    tod7_q <= tod6_q;

    c8_q   <= c7_q;
    bd8_q  <= bd7_q;
    p3_q   <= p3_d;
    tod8_q <= tod7_q;

    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    tod9_q  <= tod8_q;
  end

  assign done_o        = valid_q[Latency-1];
  assign year_o        = year_q;
  assign month_o       = month_q;
  assign day_o         = day_q;
  assign hour_o        = tod9_q.hour;
  assign minute_o      = tod9_q.minute;
  assign second_o      = tod9_q.second;
  assign millisecond_o = tod9_q.msec;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##9 done_o)
    else $error("transaction did not complete after pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 9))
    else $error("result without matching transaction");

  a_date_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1 && day_o <= 5'd31))
    else $error("calendar date out of range");

  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59
                && millisecond_o <= 10'd999))
    else $error("time of day out of range");

endmodule
`default_nettype wire
